/* hdl/pvam_pkg.sv */
`timescale 1ns / 1ps
package pvam_pkg;

   localparam int NUM_VOICES_DEF  = 8;
   localparam int NUM_SAMPLES_DEF = 16;
   localparam int PCM_WORDS_DEF   = 65536;
   localparam int MAX_SAMPLES     = 16;
   localparam logic [15:0] UNITY_GAIN = 16'd4096;

   typedef enum logic [3:0] {
      OP_WRITE_PCM  = 4'd0,
      OP_WRITE_DESC = 4'd1,
      OP_PLAY       = 4'd2,
      OP_PLAY_VOICE = 4'd3,
      OP_STOP_ALL   = 4'd4,
      OP_STOP_VOICE = 4'd5,
      OP_RESERVE    = 4'd6,
      OP_GAIN       = 4'd7,
      OP_TICK       = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_SAMPLE = 2'd1,
      ST_BAD_VOICE  = 2'd2,
      ST_NO_VOICE   = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0]         operation;
      logic [3:0]         sample_id;
      logic [3:0]         channel;
      logic [15:0]        word_address;
      logic signed [15:0] word_value;
      logic [15:0]        start_address;
      logic [16:0]        sample_length;
      logic [15:0]        loop_start;
      logic               loop_enable;
      logic               stereo_flag;
      logic [15:0]        gain_value;
      logic               reserve_flag;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_out;
      logic signed [15:0] right_out;
      logic [1:0]         status;
      logic [3:0]         channel_used;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // latch request, apply writes, stops, reserves, gains
      logic scan;      // examine voice at scan index
      logic fetch;     // issue left memory read
      logic fetch_r;   // issue right memory read
      logic mix;       // accumulate scaled words
      logic step;      // advance scan index
      logic finish;    // commit play decision, build result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tick;
      logic is_play;
      logic scan_last;
      logic voice_plays;  // scanned voice active and reading memory
   } stat_type;

endpackage

/* hdl/pvam_ctrl.sv */
`timescale 1ns / 1ps
module pvam_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  pvam_pkg::stat_type stat,
   output pvam_pkg::cmd_type  cmd
);
   import pvam_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_RDL   = 7'b0000100,
      S_RDR   = 7'b0001000,
      S_MIX   = 7'b0010000,
      S_DONE  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   // sequence one item
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.is_tick && stat.voice_plays) begin
               state_in = S_RDL;
            end else if ((stat.is_tick || stat.is_play) && !stat.scan_last) begin
               cmd.step = 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_RDL: begin
            cmd.fetch = 1'b1;
            state_in  = S_RDR;
         end
         S_RDR: begin
            cmd.fetch_r = 1'b1;
            state_in    = S_MIX;
         end
         S_MIX: begin
            cmd.mix = 1'b1;
            if (stat.scan_last) begin
               state_in = S_DONE;
            end else begin
               cmd.step = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

/* hdl/pvam_datapath.sv */
`timescale 1ns / 1ps
module pvam_datapath #(
   parameter int NUM_VOICES  = pvam_pkg::NUM_VOICES_DEF,
   parameter int NUM_SAMPLES = pvam_pkg::NUM_SAMPLES_DEF,
   parameter int PCM_WORDS   = pvam_pkg::PCM_WORDS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  pvam_pkg::req_type  req_data,
   input  pvam_pkg::cmd_type  cmd,
   output pvam_pkg::stat_type stat,
   output pvam_pkg::rsp_type  rsp_data
);
   import pvam_pkg::*;

   localparam int VW = $clog2(NUM_VOICES);
   localparam int AW = $clog2(PCM_WORDS);

   typedef struct packed {
      logic [15:0] start;
      logic [16:0] length;
      logic [15:0] loop_frame;
      logic        loop_on;
      logic        stereo;
   } desc_type;

   logic [15:0] pcm_mem [PCM_WORDS];
   desc_type    desc_ff [MAX_SAMPLES];
   logic [MAX_SAMPLES-1:0] dvalid_ff;
   logic [NUM_VOICES-1:0]  active_ff, reserved_ff;
   logic [3:0]  vsample_ff [NUM_VOICES];
   logic [16:0] vpos_ff    [NUM_VOICES];
   logic [31:0] vage_ff    [NUM_VOICES];
   logic [15:0] vgain_ff   [NUM_VOICES];

   req_type     rq_ff;
   logic [VW:0] idx_ff;
   logic [VW-1:0] vi;
   logic [15:0] rd_ff;
   logic signed [15:0] wl_ff;
   logic [15:0] left_ff, right_ff;
   logic        found_ff;      // retrigger voice found
   logic [VW-1:0] pick_ff;
   logic        fre_ff;        // free voice found
   logic [VW-1:0] fre_pick_ff;
   logic [31:0] best_ff;
   logic        steal_ff;
   logic [VW-1:0] steal_pick_ff;
   logic [AW-1:0] addr_ff;
   rsp_type     rsp_ff;

   assign vi = idx_ff[VW-1:0];

   // scanned voice view
   desc_type    d;
   logic        mult2;
   logic [17:0] widx, lidx;
   logic        past_end, plays;
   logic [16:0] play_pos;
   logic [15:0] addr_l;
   logic        samp_ok, ch_ok;

   always_comb begin
      d        = desc_ff[vsample_ff[vi]];
      mult2    = d.stereo;
      widx     = mult2 ? {vpos_ff[vi], 1'b0} : {1'b0, vpos_ff[vi]};
      lidx     = mult2 ? {1'b0, d.loop_frame, 1'b0} : {2'b0, d.loop_frame};
      past_end = widx >= {1'b0, d.length};
      plays    = active_ff[vi] && (!past_end || d.loop_on);
      play_pos = past_end ? {1'b0, d.loop_frame} : vpos_ff[vi];
      addr_l   = d.start + (past_end ? lidx[15:0] : widx[15:0]);
      samp_ok  = (int'(rq_ff.sample_id) < NUM_SAMPLES) && dvalid_ff[rq_ff.sample_id];
      ch_ok    = int'(rq_ff.channel) < NUM_VOICES;
   end

   assign stat.is_tick     = rq_ff.operation == OP_TICK;
   assign stat.is_play     = (rq_ff.operation == OP_PLAY) && samp_ok;
   assign stat.scan_last   = int'(idx_ff) == NUM_VOICES - 1;
   assign stat.voice_plays = plays;
   assign rsp_data         = rsp_ff;

   // memory port: at most one write and one read per cycle
   always_ff @(posedge clock) begin
      if (cmd.load && req_data.operation == OP_WRITE_PCM) begin
         pcm_mem[req_data.word_address[AW-1:0]] <= req_data.word_value;
      end
      rd_ff <= pcm_mem[addr_ff];
   end

   // gain scaling: truncate toward zero, saturate
   function automatic logic [15:0] scale(input logic signed [15:0] w,
                                         input logic [15:0] g);
      logic signed [32:0] p;
      logic signed [32:0] q;
      begin
         p = w * $signed({1'b0, g});
         q = p[32] ? -((-p) >>> 12) : (p >>> 12);
         if (q > 33'sd32767) scale = 16'h7FFF;
         else if (q < -33'sd32768) scale = 16'h8000;
         else scale = q[15:0];
      end
   endfunction

   // mono uses the left word on both sides
   logic [15:0] gs;
   logic [15:0] sl, sr_use;
   assign gs     = vgain_ff[vi];
   assign sl     = scale(wl_ff, gs);
   assign sr_use = d.stereo ? scale($signed(rd_ff), gs) : sl;

   logic [VW-1:0] final_pick;
   logic          final_found;
   always_comb begin
      final_found = found_ff || fre_ff || steal_ff;
      final_pick  = found_ff ? pick_ff : (fre_ff ? fre_pick_ff : steal_pick_ff);
   end

   // result status and chosen voice
   status_type fin_status;
   logic [3:0] fin_used;
   always_comb begin
      fin_status = ST_OK;
      fin_used   = '0;
      unique case (rq_ff.operation) inside
         OP_WRITE_DESC: begin
            if (int'(rq_ff.sample_id) >= NUM_SAMPLES) fin_status = ST_BAD_SAMPLE;
         end
         OP_PLAY: begin
            if (!samp_ok) fin_status = ST_BAD_SAMPLE;
            else if (!final_found) fin_status = ST_NO_VOICE;
            else fin_used = 4'(final_pick);
         end
         OP_PLAY_VOICE: begin
            if (!samp_ok) fin_status = ST_BAD_SAMPLE;
            else if (!ch_ok) fin_status = ST_BAD_VOICE;
            else fin_used = rq_ff.channel;
         end
         OP_STOP_VOICE, OP_RESERVE, OP_GAIN: begin
            if (!ch_ok) fin_status = ST_BAD_VOICE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvalid_ff   <= '0;
         active_ff   <= '0;
         reserved_ff <= '0;
         for (int i = 0; i < NUM_VOICES; i++) begin
            vsample_ff[i] <= '0;
            vpos_ff[i]    <= '0;
            vage_ff[i]    <= '0;
            vgain_ff[i]   <= UNITY_GAIN;
         end
         idx_ff <= '0;
      end else begin
         // latch item, apply descriptor, stop, reserve and gain writes
         if (cmd.load) begin
            rq_ff    <= req_data;
            idx_ff   <= '0;
            left_ff  <= '0;
            right_ff <= '0;
            found_ff <= 1'b0;
            fre_ff   <= 1'b0;
            steal_ff <= 1'b0;
            best_ff  <= '0;
            pick_ff  <= '0;
            fre_pick_ff <= '0;
            steal_pick_ff <= '0;
            unique case (req_data.operation)
               OP_WRITE_DESC: begin
                  if (int'(req_data.sample_id) < NUM_SAMPLES) begin
                     desc_ff[req_data.sample_id] <= '{req_data.start_address,
                        req_data.sample_length, req_data.loop_start,
                        req_data.loop_enable, req_data.stereo_flag};
                     dvalid_ff[req_data.sample_id] <= 1'b1;
                  end
               end
               OP_STOP_ALL: active_ff <= '0;
               OP_STOP_VOICE: begin
                  if (int'(req_data.channel) < NUM_VOICES)
                     active_ff[req_data.channel[VW-1:0]] <= 1'b0;
               end
               OP_RESERVE: begin
                  if (int'(req_data.channel) < NUM_VOICES)
                     reserved_ff[req_data.channel[VW-1:0]] <= req_data.reserve_flag;
               end
               OP_GAIN: begin
                  if (int'(req_data.channel) < NUM_VOICES)
                     vgain_ff[req_data.channel[VW-1:0]] <= req_data.gain_value;
               end
               default: ;
            endcase
         end
         // scan one voice
         if (cmd.scan) begin
            if (stat.is_tick && active_ff[vi]) begin
               vage_ff[vi] <= vage_ff[vi] + 32'd1;
               if (!plays) begin
                  active_ff[vi] <= 1'b0;
                  vpos_ff[vi]   <= '0;
               end else begin
                  vpos_ff[vi] <= play_pos + 17'd1;
                  addr_ff     <= addr_l[AW-1:0];
               end
            end
            if (stat.is_play) begin
               if (!found_ff && active_ff[vi] && vsample_ff[vi] == rq_ff.sample_id) begin
                  found_ff <= 1'b1;
                  pick_ff  <= vi;
               end
               if (!fre_ff && !active_ff[vi] && !reserved_ff[vi]) begin
                  fre_ff      <= 1'b1;
                  fre_pick_ff <= vi;
               end
               if (!reserved_ff[vi] && vage_ff[vi] > best_ff) begin
                  best_ff       <= vage_ff[vi];
                  steal_ff      <= 1'b1;
                  steal_pick_ff <= vi;
               end
            end
         end
         // read right word in the cycle after the left one
         if (cmd.fetch) begin
            addr_ff <= addr_ff + (d.stereo ? AW'(1) : AW'(0));
         end
         if (cmd.fetch_r) wl_ff <= rd_ff;
         // accumulate scaled words with 16-bit wrap
         if (cmd.mix) begin
            left_ff  <= left_ff + sl;
            right_ff <= right_ff + sr_use;
         end
         if (cmd.step) idx_ff <= idx_ff + 1'b1;
         // build result, bind the chosen voice
         if (cmd.finish) begin
            rsp_ff <= {left_ff, right_ff, fin_status, fin_used};
            if (rq_ff.operation == OP_PLAY && samp_ok && final_found) begin
               active_ff[final_pick]  <= 1'b1;
               vsample_ff[final_pick] <= rq_ff.sample_id;
               vpos_ff[final_pick]    <= '0;
               vage_ff[final_pick]    <= '0;
            end
            if (rq_ff.operation == OP_PLAY_VOICE && samp_ok && ch_ok) begin
               active_ff[rq_ff.channel[VW-1:0]]  <= 1'b1;
               vsample_ff[rq_ff.channel[VW-1:0]] <= rq_ff.sample_id;
               vpos_ff[rq_ff.channel[VW-1:0]]    <= '0;
               vage_ff[rq_ff.channel[VW-1:0]]    <= '0;
            end
         end
      end
   end
endmodule

/* hdl/pcm_voice_allocator_mixer_top.sv */
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_data (req_type)
// rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_type)
// A tick scans every voice and, for each playing voice, reads the left and
// then the right word through the single sample memory port.
// A play scans every voice; the block takes one item at a time.
// Synchronous active-high reset clears voices and descriptor valid bits.
// A stalled result holds the block; the next item waits for it.
module pcm_voice_allocator_mixer_top #(
   parameter int NUM_VOICES  = pvam_pkg::NUM_VOICES_DEF,
   parameter int NUM_SAMPLES = pvam_pkg::NUM_SAMPLES_DEF,
   parameter int PCM_WORDS   = pvam_pkg::PCM_WORDS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pvam_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pvam_pkg::rsp_type rsp_data
);
   import pvam_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pvam_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .cmd
   );

   pvam_datapath #(
      .NUM_VOICES(NUM_VOICES), .NUM_SAMPLES(NUM_SAMPLES), .PCM_WORDS(PCM_WORDS)
   ) u_dp (
      .clock, .reset, .req_data, .cmd, .stat, .rsp_data
   );

`ifndef ASSERT_OFF
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.fetch, cmd.fetch_r, cmd.mix, cmd.finish}))
      else $error("several phases at once");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !req_ready)
      else $error("item accepted while busy");
   a_finish_then_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> !req_ready)
      else $error("result skipped");
`endif
endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import pvam_pkg::*;

   localparam int VOICES    = NUM_VOICES_DEF;
   localparam int SAMPLES   = NUM_SAMPLES_DEF;
   localparam int WATCH_MAX = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   pcm_voice_allocator_mixer_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   // mixer model state
   logic [15:0] mem_word [int];
   logic        desc_ok [SAMPLES];
   logic [15:0] desc_start [SAMPLES];
   logic [16:0] desc_len [SAMPLES];
   logic [15:0] desc_loop [SAMPLES];
   logic        desc_loop_on [SAMPLES];
   logic        desc_stereo [SAMPLES];
   logic        v_active [VOICES];
   logic [3:0]  v_sample [VOICES];
   logic [16:0] v_pos [VOICES];
   logic [31:0] v_age [VOICES];
   logic        v_rsv [VOICES];
   logic [15:0] v_gain [VOICES];

   req_type pending_items[$];
   rsp_type expected_mix[$];
   int      errors = 0;
   int      send_idle = 23;
   int      recv_idle = 47;
   int      hold_off = 0;
   int      quiet = 0;

   function automatic logic signed [15:0] rd_word(logic [15:0] a);
      return mem_word.exists(int'(a)) ? mem_word[int'(a)] : 16'sd0;
   endfunction

   function automatic logic [15:0] apply_gain(logic signed [15:0] w, logic [15:0] g);
      longint p, q;
      p = longint'(w) * longint'(g);
      q = (p >= 0) ? p / 4096 : -((-p) / 4096);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
   endfunction

   function automatic void bind_v(int v, logic [3:0] id);
      v_active[v] = 1; v_sample[v] = id; v_pos[v] = 0; v_age[v] = 0;
   endfunction

   function automatic rsp_type predict_mix(req_type r);
      rsp_type o;
      bit found;
      int pick;
      logic [31:0] best;
      logic [17:0] idx;
      logic [3:0] s;
      logic signed [15:0] wl, wr;
      o = '0; found = 0; pick = 0; best = 0;
      case (r.operation)
         OP_WRITE_PCM: mem_word[int'(r.word_address)] = r.word_value;
         OP_WRITE_DESC: begin
            s = r.sample_id;
            desc_start[s] = r.start_address; desc_len[s] = r.sample_length;
            desc_loop[s] = r.loop_start; desc_loop_on[s] = r.loop_enable;
            desc_stereo[s] = r.stereo_flag; desc_ok[s] = 1;
         end
         OP_PLAY: begin
            if (!desc_ok[r.sample_id]) o.status = ST_BAD_SAMPLE;
            else begin
               for (int v = 0; v < VOICES && !found; v++)
                  if (v_active[v] && v_sample[v] == r.sample_id) begin pick = v; found = 1; end
               for (int v = 0; v < VOICES && !found; v++)
                  if (!v_active[v] && !v_rsv[v]) begin pick = v; found = 1; end
               if (!found)
                  for (int v = 0; v < VOICES; v++)
                     if (!v_rsv[v] && v_age[v] > best) begin
                        best = v_age[v]; pick = v; found = 1;
                     end
               if (!found) o.status = ST_NO_VOICE;
               else begin bind_v(pick, r.sample_id); o.channel_used = 4'(pick); end
            end
         end
         OP_PLAY_VOICE: begin
            if (!desc_ok[r.sample_id]) o.status = ST_BAD_SAMPLE;
            else if (r.channel >= VOICES) o.status = ST_BAD_VOICE;
            else begin
               bind_v(int'(r.channel), r.sample_id); o.channel_used = r.channel;
            end
         end
         OP_STOP_ALL: for (int v = 0; v < VOICES; v++) v_active[v] = 0;
         OP_STOP_VOICE:
            if (r.channel >= VOICES) o.status = ST_BAD_VOICE;
            else v_active[r.channel] = 0;
         OP_RESERVE:
            if (r.channel >= VOICES) o.status = ST_BAD_VOICE;
            else v_rsv[r.channel] = r.reserve_flag;
         OP_GAIN:
            if (r.channel >= VOICES) o.status = ST_BAD_VOICE;
            else v_gain[r.channel] = r.gain_value;
         OP_TICK:
            for (int v = 0; v < VOICES; v++) begin
               if (v_active[v]) begin
                  v_age[v]++;
                  s = v_sample[v];
                  idx = desc_stereo[s] ? {v_pos[v], 1'b0} : {1'b0, v_pos[v]};
                  if (idx >= desc_len[s] && !desc_loop_on[s]) begin
                     v_active[v] = 0; v_pos[v] = 0;
                  end else begin
                     if (idx >= desc_len[s]) begin
                        v_pos[v] = desc_loop[s];
                        idx = desc_stereo[s] ? {v_pos[v], 1'b0} : {1'b0, v_pos[v]};
                     end
                     wl = rd_word(desc_start[s] + idx[15:0]);
                     wr = desc_stereo[s] ? rd_word(desc_start[s] + idx[15:0] + 16'd1) : wl;
                     o.left_out = o.left_out + apply_gain(wl, v_gain[v]);
                     o.right_out = o.right_out + apply_gain(wr, v_gain[v]);
                     v_pos[v] = v_pos[v] + 17'd1;
                  end
               end
            end
         default: ;
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   // driver: take the next pending item, hold it until accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_mix.push_back(predict_mix(req_data));
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_data <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid && pending_items.size() > 0 &&
                      $urandom_range(99) >= send_idle) begin
            req_data  <= pending_items.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // monitor: compare each result with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_mix.size() == 0) begin
               $display("result with nothing expected");
               errors++;
            end else begin
               e = expected_mix.pop_front();
               if (rsp_data.left_out !== e.left_out)
                  report_mismatch("left", rsp_data.left_out, e.left_out);
               if (rsp_data.right_out !== e.right_out)
                  report_mismatch("right", rsp_data.right_out, e.right_out);
               if (rsp_data.status !== e.status)
                  report_mismatch("status", rsp_data.status, e.status);
               if (rsp_data.channel_used !== e.channel_used)
                  report_mismatch("channel", rsp_data.channel_used, e.channel_used);
            end
         end
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   // watchdog on cycles without any accepted item or result
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet <= 0;
      else if (!reset) quiet <= quiet + 1;
      if (quiet >= WATCH_MAX) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // random item; lengths stay short so every read hits a preloaded word
   function automatic req_type rand_item(int op);
      req_type r;
      r = '0;
      r.operation     = 4'(op);
      r.sample_id     = 4'($urandom_range(SAMPLES - 1));
      r.channel       = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                                 : 4'($urandom_range(VOICES - 1));
      r.word_address  = 16'($urandom_range(255));
      r.word_value    = 16'($urandom);
      r.start_address = ($urandom_range(9) == 0) ? 16'hFFF8 : 16'($urandom_range(200));
      r.sample_length = 17'($urandom_range(24));
      r.loop_start    = ($urandom_range(19) == 0) ? 16'hFFFF : 16'($urandom_range(12));
      r.loop_enable   = 1'($urandom);
      r.stereo_flag   = 1'($urandom);
      r.gain_value    = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(8192));
      r.reserve_flag  = ($urandom_range(3) == 0);
      return r;
   endfunction

   function automatic void push_op(int op);
      pending_items.push_back(rand_item(op));
   endfunction

   initial begin
      req_type r;
      int pick;
      for (int s = 0; s < SAMPLES; s++) desc_ok[s] = 0;
      for (int v = 0; v < VOICES; v++) begin
         v_active[v] = 0; v_sample[v] = 0; v_pos[v] = 0; v_age[v] = 0;
         v_rsv[v] = 0; v_gain[v] = UNITY_GAIN;
      end
      // preload every word that a descriptor may reach, including wrap area
      for (int a = 0; a < 256; a++) begin
         r = rand_item(OP_WRITE_PCM); r.word_address = 16'(a);
         if (a == 0) r.word_value = 16'sh7FFF;
         if (a == 1) r.word_value = 16'sh8000;
         pending_items.push_back(r);
      end
      for (int a = 16'hFFF6; a <= 16'hFFFF; a++) begin
         r = rand_item(OP_WRITE_PCM); r.word_address = 16'(a); pending_items.push_back(r);
      end
      r = rand_item(OP_WRITE_PCM); r.word_address = 16'hFFFF; r.word_value = 16'sh7FFF;
      pending_items.push_back(r);
      // directed: play before any descriptor, then extremes and special cases
      push_op(OP_PLAY);
      r = rand_item(OP_WRITE_DESC); r.sample_id = 0; r.start_address = 0;
      r.sample_length = 4; r.loop_enable = 1; r.loop_start = 16'hFFFF; r.stereo_flag = 1;
      pending_items.push_back(r);
      r = rand_item(OP_WRITE_DESC); r.sample_id = 15; r.start_address = 16'hFFFF;
      r.sample_length = 17'h10000; r.loop_enable = 0; r.stereo_flag = 0;
      pending_items.push_back(r);
      r = rand_item(OP_PLAY_VOICE); r.sample_id = 3; r.channel = 15; pending_items.push_back(r);
      r = rand_item(OP_PLAY_VOICE); r.sample_id = 0; r.channel = 15; pending_items.push_back(r);
      r = rand_item(OP_GAIN); r.channel = 0; r.gain_value = 16'hFFFF; pending_items.push_back(r);
      r = rand_item(OP_GAIN); r.channel = 1; r.gain_value = 0; pending_items.push_back(r);
      r = rand_item(OP_RESERVE); r.channel = 15; pending_items.push_back(r);
      for (int v = 0; v < VOICES; v++) begin
         r = rand_item(OP_PLAY_VOICE); r.sample_id = (v & 1) ? 4'd15 : 4'd0;
         r.channel = 4'(v);
         pending_items.push_back(r);
      end
      push_op(OP_TICK); push_op(OP_TICK); push_op(OP_TICK);
      // shrink the full-length sample before it walks past the preloaded words
      r = rand_item(OP_WRITE_DESC); r.sample_id = 15; pending_items.push_back(r);
      r = rand_item(OP_PLAY); r.sample_id = 0; pending_items.push_back(r);
      for (int v = 0; v < VOICES; v++) begin
         r = rand_item(OP_RESERVE); r.channel = 4'(v); r.reserve_flag = 1;
         pending_items.push_back(r);
      end
      r = rand_item(OP_PLAY); r.sample_id = 7; pending_items.push_back(r);
      r = rand_item(OP_WRITE_DESC); r.sample_id = 7; pending_items.push_back(r);
      r = rand_item(OP_PLAY); r.sample_id = 7; pending_items.push_back(r);
      push_op(OP_STOP_VOICE); push_op(OP_STOP_ALL);
      r = rand_item(OP_STOP_VOICE); r.channel = 12; pending_items.push_back(r);
      r = '0; r.operation = 4'd15; pending_items.push_back(r);
      for (int s = 0; s < SAMPLES; s++) push_op(OP_WRITE_DESC);
      for (int v = 0; v < VOICES; v++) begin
         r = rand_item(OP_RESERVE); r.channel = 4'(v); r.reserve_flag = 0;
         pending_items.push_back(r);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // random phases: mostly plays and ticks, some noise
      for (int phase = 0; phase < 3; phase++) begin
         for (int i = 0; i < 208; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) push_op(OP_TICK);
            else if (pick < 55) push_op(OP_PLAY);
            else if (pick < 63) push_op(OP_PLAY_VOICE);
            else if (pick < 70) push_op(OP_WRITE_DESC);
            else if (pick < 76) push_op(OP_GAIN);
            else if (pick < 82) push_op(OP_RESERVE);
            else if (pick < 88) push_op(OP_STOP_VOICE);
            else if (pick < 90) push_op(OP_STOP_ALL);
            else if (pick < 97) push_op(OP_WRITE_PCM);
            else begin r = rand_item(9); r.operation = 4'($urandom_range(15, 9));
               pending_items.push_back(r); end
         end
         if (phase == 0) begin
            @(posedge clock);
            hold_off <= 400;
         end
         wait (pending_items.size() == 0 && !req_valid && expected_mix.size() == 0);
         @(posedge clock);
         send_idle = (phase == 0) ? 47 : 0;
         recv_idle = (phase == 0) ? 23 : 0;
      end
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_mix.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
